[src/vector_angle_degrees_core_assert.svh]
// assertion macros for the angle core
`ifndef VECTOR_ANGLE_DEGREES_CORE_ASSERT_SVH
`define VECTOR_ANGLE_DEGREES_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define VAD_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define VAD_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/vad_pkg.sv]
// ----------------------------------------------------------------------------
// vad_pkg
// types and constants shared by the vector angle core
// ----------------------------------------------------------------------------
package vad_pkg;

  localparam int unsigned CordicSteps = 23;
  localparam int unsigned ZW = 26;
  localparam int unsigned XW = 36;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
  } vad_in_t;

  typedef struct packed {
    logic [15:0] angle_deg;
    logic        valid_res;
  } vad_out_t;

  // vectoring state handed from cell to cell
  typedef struct packed {
    logic                 vld;
    logic                 ok;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vad_cell_t;

  function automatic logic [21:0] atan_deg(input int unsigned i);
    logic [21:0] t;
    case (i)
      0: t = 22'd2949120;  1: t = 22'd1740967;  2: t = 22'd919879;
      3: t = 22'd466945;   4: t = 22'd234379;   5: t = 22'd117304;
      6: t = 22'd58666;    7: t = 22'd29335;    8: t = 22'd14668;
      9: t = 22'd7334;     10: t = 22'd3667;    11: t = 22'd1833;
      12: t = 22'd917;     13: t = 22'd458;     14: t = 22'd229;
      15: t = 22'd115;     16: t = 22'd57;      17: t = 22'd29;
      18: t = 22'd14;      19: t = 22'd7;       20: t = 22'd4;
      21: t = 22'd2;       22: t = 22'd1;
      default: t = 22'd0;
    endcase
    return t;
  endfunction

endpackage

[src/vad_cordic_cell.sv]
// ----------------------------------------------------------------------------
// vad_cordic_cell
// one registered vectoring step of the atan2 chain
// ----------------------------------------------------------------------------
module vad_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vad_pkg::vad_cell_t  cell_i,
  output vad_pkg::vad_cell_t  cell_o
);
  import vad_pkg::*;

  vad_cell_t cell_d, cell_q;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] a;

  always_comb begin
    xs = cell_i.x >>> Step;
    ys = cell_i.y >>> Step;
    a  = ZW'(signed'({1'b0, atan_deg(Step)}));
    cell_d = cell_i;
    if (cell_i.y > 0) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + a;
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - a;
    end
  end

  // only the valid flag is reset, the payload just holds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.vld <= 1'b0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule

[src/vad_front.sv]
// ----------------------------------------------------------------------------
// vad_front
// edge vectors, normalization, dot and cross products, magnitude
// ----------------------------------------------------------------------------
module vad_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  vad_pkg::vad_in_t   data_i,
  output vad_pkg::vad_cell_t cell_o
);
  import vad_pkg::*;

  // stage 1: differences
  logic        s1_vld_q, s1_ok;
  logic signed [32:0] a_q [3], b_q [3];
  logic signed [32:0] a_d [3], b_d [3];

  always_comb begin
    a_d[0] = 33'(data_i.first_x) - 33'(data_i.vertex_x);
    a_d[1] = 33'(data_i.first_y) - 33'(data_i.vertex_y);
    a_d[2] = 33'(data_i.first_z) - 33'(data_i.vertex_z);
    b_d[0] = 33'(data_i.second_x) - 33'(data_i.vertex_x);
    b_d[1] = 33'(data_i.second_y) - 33'(data_i.vertex_y);
    b_d[2] = 33'(data_i.second_z) - 33'(data_i.vertex_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  // stage 2: shift amount per vector from leading one of max magnitude
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic signed [6:0] shamt(input logic [32:0] m);
    logic signed [6:0] s;
    s = 7'sd0;
    for (int i = 0; i < 33; i++) begin
      if (m[i]) s = 7'(i) - 7'sd29;
    end
    return s;
  endfunction

  function automatic logic signed [31:0] scl(input logic signed [32:0] v,
                                             input logic signed [6:0] s);
    logic [32:0] m;
    logic [63:0] q;
    m = mag33(v);
    if (s >= 0) q = 64'(m) >> s;
    else q = 64'(m) << (-s);
    return v[32] ? -32'(q) : 32'(q);
  endfunction

  logic [32:0] ma, mb;
  logic signed [6:0] sa_q, sb_q;
  logic signed [32:0] a2_q [3], b2_q [3];
  logic s2_vld_q, s2_ok_q;

  always_comb begin
    ma = mag33(a_q[0]) | mag33(a_q[1]) | mag33(a_q[2]);
    mb = mag33(b_q[0]) | mag33(b_q[1]) | mag33(b_q[2]);
    s1_ok = (ma != '0) && (mb != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  // or of magnitudes has the same leading one as the max
  always_ff @(posedge clk_i) begin
    sa_q    <= shamt(ma);
    sb_q    <= shamt(mb);
    a2_q    <= a_q;
    b2_q    <= b_q;
    s2_ok_q <= s1_ok;
  end

  // stage 3: scaled vectors
  logic signed [31:0] an_q [3], bn_q [3];
  logic s3_vld_q, s3_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      an_q[i] <= scl(a2_q[i], sa_q);
      bn_q[i] <= scl(b2_q[i], sb_q);
    end
    s3_ok_q <= s2_ok_q;
  end

  // stage 4: nine products, registered
  logic signed [61:0] p_q [3][3];
  logic s4_vld_q, s4_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_q[i][j] <= 62'(an_q[i]) * 62'(bn_q[j]);
      end
    end
    s4_ok_q <= s3_ok_q;
  end

  // stage 5: dot and cross, floor shift by 31
  logic signed [32:0] dot_q, c_q [3];
  logic s5_vld_q, s5_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dot_q  <= 33'((64'(p_q[0][0]) + 64'(p_q[1][1]) + 64'(p_q[2][2])) >>> 31);
    c_q[0] <= 33'((64'(p_q[1][2]) - 64'(p_q[2][1])) >>> 31);
    c_q[1] <= 33'((64'(p_q[2][0]) - 64'(p_q[0][2])) >>> 31);
    c_q[2] <= 33'((64'(p_q[0][1]) - 64'(p_q[1][0])) >>> 31);
    s5_ok_q <= s4_ok_q;
  end

  // stage 6: squares (|c| at most 2^30)
  logic [60:0] sq_q [3];
  logic signed [32:0] dot6_q;
  logic s6_vld_q, s6_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= 61'(mag33(c_q[i])) * 61'(mag33(c_q[i]));
    end
    dot6_q  <= dot_q;
    s6_ok_q <= s5_ok_q;
  end

  // stage 7: sum of squares, below 2^62
  logic [61:0] n_q;
  logic signed [32:0] dot7_q;
  logic s7_vld_q, s7_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= 62'(sq_q[0]) + 62'(sq_q[1]) + 62'(sq_q[2]);
    dot7_q  <= dot6_q;
    s7_ok_q <= s6_ok_q;
  end

  // pipelined square root, one result bit per stage
  localparam int unsigned RB = 31;

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    logic [61:0]        n_in, rn_q, trial;
    logic [RB-1:0]      r_in, rr_q, rnew;
    logic signed [32:0] d_in, rd_q;
    logic               v_in, rv_q, o_in, ro_q;

    if (k == 0) begin : g_head
      assign n_in = n_q;
      assign r_in = '0;
      assign d_in = dot7_q;
      assign v_in = s7_vld_q;
      assign o_in = s7_ok_q;
    end else begin : g_tail
      assign n_in = g_sqrt[k-1].rn_q;
      assign r_in = g_sqrt[k-1].rr_q;
      assign d_in = g_sqrt[k-1].rd_q;
      assign v_in = g_sqrt[k-1].rv_q;
      assign o_in = g_sqrt[k-1].ro_q;
    end

    always_comb begin
      rnew  = r_in | (RB'(1) << (RB - 1 - k));
      trial = 62'(rnew) * 62'(rnew);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q <= 1'b0;
      end else begin
        rv_q <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rr_q <= (trial <= n_in) ? rnew : r_in;
      rn_q <= n_in;
      rd_q <= d_in;
      ro_q <= o_in;
    end
  end

  logic [RB-1:0]      root;
  logic signed [32:0] dot_r;

  assign root  = g_sqrt[RB-1].rr_q;
  assign dot_r = g_sqrt[RB-1].rd_q;

  // pre-rotation for negative dot
  always_comb begin
    cell_o.vld = g_sqrt[RB-1].rv_q;
    cell_o.ok  = g_sqrt[RB-1].ro_q;
    if (dot_r < 0) begin
      cell_o.x = XW'(signed'({1'b0, root}));
      cell_o.y = -XW'(dot_r);
      cell_o.z = ZW'(90 * 65536);
    end else begin
      cell_o.x = XW'(dot_r);
      cell_o.y = XW'(signed'({1'b0, root}));
      cell_o.z = '0;
    end
  end
endmodule

[src/vector_angle_degrees_core.sv]
// one item accepted every cycle; start travels through 7 front stages, the 31-cell
// square root chain, the 23-cell vectoring chain and the output register to done_o
// busy is always low; the receiver cannot stall so no backpressure exists
// reset clears all valid flags in the pipe; payload is not reset
// ----------------------------------------------------------------------------
// vector_angle_degrees_core
// pipelined angle between two 3d edges in degrees, q8.8
// ----------------------------------------------------------------------------
module vector_angle_degrees_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  vad_pkg::vad_in_t  data_i,
  output logic              done_o,
  output vad_pkg::vad_out_t result_o
);
  import vad_pkg::*;

  vad_cell_t chain [CordicSteps+1];

  assign busy = 1'b0;

  vad_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start),
    .data_i (data_i),
    .cell_o (chain[0])
  );

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
    vad_cordic_cell #(.Step(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  logic signed [ZW-1:0] zc;
  logic [ZW-1:0] zr;
  logic done_q;
  vad_out_t res_q, res_d;

  always_comb begin
    zc = chain[CordicSteps].z;
    if (zc < 0) zc = '0;
    if (zc > ZW'(180 * 65536)) zc = ZW'(180 * 65536);
    zr = (ZW'(zc) + ZW'(128)) >> 8;
    if (zr > ZW'(46080)) zr = ZW'(46080);
    res_d.angle_deg = chain[CordicSteps].ok ? zr[15:0] : 16'd0;
    res_d.valid_res = chain[CordicSteps].ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain[CordicSteps].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;
endmodule

[src/vad_checker.sv]
// ----------------------------------------------------------------------------
// vad_checker
// port-level checks on the angle core
// ----------------------------------------------------------------------------
`include "vector_angle_degrees_core_assert.svh"

module vad_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input vad_pkg::vad_out_t result_o
);
  logic invalid_out;

  assign invalid_out = done_o && !result_o.valid_res;

  `VAD_ASSERT_IMP(a_never_busy, clk_i, rst_ni, 1'b1, !busy)
  `VAD_ASSERT_IMP(a_range, clk_i, rst_ni, done_o, result_o.angle_deg <= 16'd46080)
  `VAD_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, invalid_out, result_o.angle_deg == 16'd0)
endmodule

bind vector_angle_degrees_core vad_checker u_vad_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
